### rtl/wpp_pkg.sv
// ----------------------------------------------------------------------------
// wpp_pkg
// Shared types and constants of the RIFF WAVE 16-bit PCM stream parser.
// ----------------------------------------------------------------------------
package wpp_pkg;

    // Parser phases, one-hot coded.
    typedef enum logic [4:0] {
        PH_FILE_HDR  = 5'b00001,
        PH_CHUNK_HDR = 5'b00010,
        PH_BODY      = 5'b00100,
        PH_PAD       = 5'b01000,
        PH_SKIP      = 5'b10000
    } phase_t;

    // Status codes of the final result.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_WAVE    = 3'd1;
    localparam logic [2:0] ST_OVERRUN     = 3'd2;
    localparam logic [2:0] ST_FMT_SHORT   = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;
    localparam logic [2:0] ST_MISSING     = 3'd5;

    // Result kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Chunk tags as big-endian ASCII words.
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // Header byte positions.
    localparam logic [3:0] RIFF_LAST_BYTE  = 4'd3;
    localparam logic [3:0] FILE_HDR_LAST   = 4'd11;
    localparam logic [3:0] CHUNK_HDR_LAST  = 4'd7;

    // Format chunk rules.
    localparam logic [31:0] FMT_MIN_LENGTH = 32'd16;
    localparam logic [15:0] PCM_FORMAT     = 16'd1;
    localparam logic [15:0] PCM_BITS       = 16'd16;

    // Queue between the parser and the output stage (depth is a power of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    // One queue entry: the results caused by one input byte.
    typedef struct packed {
        logic        sample_valid;
        logic [15:0] sample;
        logic        first_of_chunk;
        logic        status_valid;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [2:0]  status;
    } wpp_entry_t;

endpackage

### rtl/wpp_if.sv
// ----------------------------------------------------------------------------
// wpp_in_if / wpp_out_if
// Valid/ready channels of the parser: file bytes in, results out.
// ----------------------------------------------------------------------------
interface wpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface wpp_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] sample;
    logic               first_of_chunk;
    logic [15:0]        channels;
    logic [31:0]        sample_rate;
    logic [2:0]         status;
    logic               last;

    modport source (
        output valid, output kind, output sample, output first_of_chunk,
        output channels, output sample_rate, output status, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input sample, input first_of_chunk,
        input channels, input sample_rate, input status, input last,
        output ready
    );
endinterface

### rtl/wpp_front.sv
// ----------------------------------------------------------------------------
// wpp_front
// Byte parser: walks the RIFF structure and queues the results of each byte.
// ----------------------------------------------------------------------------
module wpp_front (
    input  logic               clk,
    input  logic               rst_n,
    wpp_in_if.sink             byte_in,
    input  logic               queue_full,
    output logic               push,
    output wpp_pkg::wpp_entry_t push_entry
);

    wpp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  header_count_reg, header_count_next;
    logic [31:0] tag_word_reg, tag_word_next;
    logic [31:0] chunk_length_reg, chunk_length_next;
    logic [31:0] body_offset_reg, body_offset_next;
    logic [7:0]  low_byte_hold_reg, low_byte_hold_next;
    logic [15:0] format_word_reg, format_word_next;
    logic [15:0] bits_word_reg, bits_word_next;
    logic [15:0] channel_count_reg, channel_count_next;
    logic [31:0] rate_value_reg, rate_value_next;
    logic        have_format_reg, have_format_next;
    logic        have_data_reg, have_data_next;
    logic [2:0]  pending_error_reg, pending_error_next;
    logic        first_pending_reg, first_pending_next;

    logic        accept;
    logic [7:0]  b;
    logic [31:0] tag_shift;
    logic [31:0] offset_inc;
    logic        do_finish;
    logic [2:0]  st;
    wpp_pkg::wpp_entry_t entry;

    assign byte_in.ready = !queue_full;
    assign accept        = byte_in.valid && byte_in.ready;
    assign b             = byte_in.data_byte;
    assign tag_shift     = {tag_word_reg[23:0], b};
    assign offset_inc    = body_offset_reg + 32'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        tag_word_next      = tag_word_reg;
        chunk_length_next  = chunk_length_reg;
        body_offset_next   = body_offset_reg;
        low_byte_hold_next = low_byte_hold_reg;
        format_word_next   = format_word_reg;
        bits_word_next     = bits_word_reg;
        channel_count_next = channel_count_reg;
        rate_value_next    = rate_value_reg;
        have_format_next   = have_format_reg;
        have_data_next     = have_data_reg;
        pending_error_next = pending_error_reg;
        first_pending_next = first_pending_reg;
        do_finish          = 1'b0;
        st                 = wpp_pkg::ST_OK;
        entry              = '0;

        if (accept)
        begin
            case (phase_reg)
                wpp_pkg::PH_FILE_HDR:
                begin
                    tag_word_next = tag_shift;
                    if ((header_count_reg == wpp_pkg::RIFF_LAST_BYTE
                            && tag_shift != wpp_pkg::TAG_RIFF)
                        || (header_count_reg == wpp_pkg::FILE_HDR_LAST
                            && tag_shift != wpp_pkg::TAG_WAVE))
                    begin
                        pending_error_next = wpp_pkg::ST_NOT_WAVE;
                        phase_next         = wpp_pkg::PH_SKIP;
                    end
                    else if (header_count_reg == wpp_pkg::FILE_HDR_LAST)
                    begin
                        header_count_next = 4'd0;
                        phase_next        = wpp_pkg::PH_CHUNK_HDR;
                    end
                    else
                    begin
                        header_count_next = header_count_reg + 4'd1;
                    end
                end
                wpp_pkg::PH_CHUNK_HDR:
                begin
                    if (!header_count_reg[2])
                    begin
                        // Tag bytes; the length is cleared at the start of a header.
                        tag_word_next = tag_shift;
                        if (header_count_reg == 4'd0)
                        begin
                            chunk_length_next = 32'd0;
                        end
                    end
                    else
                    begin
                        case (header_count_reg[1:0])
                            2'd0:    chunk_length_next[7:0]   = b;
                            2'd1:    chunk_length_next[15:8]  = b;
                            2'd2:    chunk_length_next[23:16] = b;
                            default: chunk_length_next[31:24] = b;
                        endcase
                    end
                    if (header_count_reg == wpp_pkg::CHUNK_HDR_LAST)
                    begin
                        header_count_next  = 4'd0;
                        body_offset_next   = 32'd0;
                        low_byte_hold_next = 8'd0;
                        first_pending_next = (tag_word_next == wpp_pkg::TAG_DATA);
                        if (chunk_length_next == 32'd0)
                        begin
                            do_finish = 1'b1;
                        end
                        else
                        begin
                            phase_next = wpp_pkg::PH_BODY;
                        end
                    end
                    else
                    begin
                        header_count_next = header_count_reg + 4'd1;
                    end
                end
                wpp_pkg::PH_BODY:
                begin
                    if (tag_word_reg == wpp_pkg::TAG_FMT)
                    begin
                        if (body_offset_reg[31:4] == 28'd0)
                        begin
                            case (body_offset_reg[3:0])
                                4'd0:  format_word_next[7:0]   = b;
                                4'd1:  format_word_next[15:8]  = b;
                                4'd2:  channel_count_next[7:0] = b;
                                4'd3:  channel_count_next[15:8] = b;
                                4'd4:  rate_value_next[7:0]    = b;
                                4'd5:  rate_value_next[15:8]   = b;
                                4'd6:  rate_value_next[23:16]  = b;
                                4'd7:  rate_value_next[31:24]  = b;
                                4'd14: bits_word_next[7:0]     = b;
                                4'd15: bits_word_next[15:8]    = b;
                                default: ;
                            endcase
                        end
                    end
                    else if (tag_word_reg == wpp_pkg::TAG_DATA)
                    begin
                        if (body_offset_reg[0])
                        begin
                            entry.sample_valid   = 1'b1;
                            entry.sample         = {b, low_byte_hold_reg};
                            entry.first_of_chunk = first_pending_reg;
                            first_pending_next   = 1'b0;
                        end
                        else
                        begin
                            low_byte_hold_next = b;
                        end
                    end
                    body_offset_next = offset_inc;
                    if (offset_inc == chunk_length_reg)
                    begin
                        do_finish = 1'b1;
                    end
                end
                wpp_pkg::PH_PAD:
                begin
                    phase_next = wpp_pkg::PH_CHUNK_HDR;
                end
                default: ;
            endcase

            // End of a chunk body: format checks, then the optional pad byte.
            if (do_finish)
            begin
                if (tag_word_next == wpp_pkg::TAG_FMT
                    && chunk_length_next < wpp_pkg::FMT_MIN_LENGTH)
                begin
                    pending_error_next = wpp_pkg::ST_FMT_SHORT;
                    phase_next         = wpp_pkg::PH_SKIP;
                end
                else if (tag_word_next == wpp_pkg::TAG_FMT
                    && (format_word_next != wpp_pkg::PCM_FORMAT
                        || bits_word_next != wpp_pkg::PCM_BITS))
                begin
                    pending_error_next = wpp_pkg::ST_UNSUPPORTED;
                    phase_next         = wpp_pkg::PH_SKIP;
                end
                else
                begin
                    if (tag_word_next == wpp_pkg::TAG_FMT)
                    begin
                        have_format_next = 1'b1;
                    end
                    if (tag_word_next == wpp_pkg::TAG_DATA)
                    begin
                        have_data_next = 1'b1;
                    end
                    phase_next = chunk_length_next[0] ? wpp_pkg::PH_PAD
                                                      : wpp_pkg::PH_CHUNK_HDR;
                end
            end

            if (byte_in.end_of_file)
            begin
                st = pending_error_next;
                if (st == wpp_pkg::ST_OK && phase_next == wpp_pkg::PH_FILE_HDR)
                begin
                    st = wpp_pkg::ST_NOT_WAVE;
                end
                if (st == wpp_pkg::ST_OK && phase_next == wpp_pkg::PH_BODY)
                begin
                    st = wpp_pkg::ST_OVERRUN;
                end
                if (st == wpp_pkg::ST_OK && (!have_format_next || !have_data_next
                    || channel_count_next == 16'd0 || rate_value_next == 32'd0))
                begin
                    st = wpp_pkg::ST_MISSING;
                end
                entry.status_valid = 1'b1;
                entry.status       = st;
                entry.channels     = (st == wpp_pkg::ST_OK) ? channel_count_next : 16'd0;
                entry.sample_rate  = (st == wpp_pkg::ST_OK) ? rate_value_next : 32'd0;

                // The next byte starts a new file.
                phase_next         = wpp_pkg::PH_FILE_HDR;
                header_count_next  = 4'd0;
                tag_word_next      = 32'd0;
                chunk_length_next  = 32'd0;
                body_offset_next   = 32'd0;
                low_byte_hold_next = 8'd0;
                format_word_next   = 16'd0;
                bits_word_next     = 16'd0;
                channel_count_next = 16'd0;
                rate_value_next    = 32'd0;
                have_format_next   = 1'b0;
                have_data_next     = 1'b0;
                pending_error_next = wpp_pkg::ST_OK;
                first_pending_next = 1'b0;
            end
        end
    end

    assign push       = accept && (entry.sample_valid || entry.status_valid);
    assign push_entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= wpp_pkg::PH_FILE_HDR;
            header_count_reg  <= 4'd0;
            tag_word_reg      <= 32'd0;
            chunk_length_reg  <= 32'd0;
            body_offset_reg   <= 32'd0;
            low_byte_hold_reg <= 8'd0;
            format_word_reg   <= 16'd0;
            bits_word_reg     <= 16'd0;
            channel_count_reg <= 16'd0;
            rate_value_reg    <= 32'd0;
            have_format_reg   <= 1'b0;
            have_data_reg     <= 1'b0;
            pending_error_reg <= wpp_pkg::ST_OK;
            first_pending_reg <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            tag_word_reg      <= tag_word_next;
            chunk_length_reg  <= chunk_length_next;
            body_offset_reg   <= body_offset_next;
            low_byte_hold_reg <= low_byte_hold_next;
            format_word_reg   <= format_word_next;
            bits_word_reg     <= bits_word_next;
            channel_count_reg <= channel_count_next;
            rate_value_reg    <= rate_value_next;
            have_format_reg   <= have_format_next;
            have_data_reg     <= have_data_next;
            pending_error_reg <= pending_error_next;
            first_pending_reg <= first_pending_next;
        end
    end

    // Skipping to end of file only happens after an error was recorded.
    a_skip_has_error: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wpp_pkg::PH_SKIP) |-> (pending_error_reg != wpp_pkg::ST_OK))
        else $error("parser skips without a recorded error");

endmodule

### rtl/wpp_queue.sv
// ----------------------------------------------------------------------------
// wpp_queue
// Short first-in first-out queue of result entries.
// ----------------------------------------------------------------------------
module wpp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wpp_pkg::wpp_entry_t push_entry,
    input  logic                pop,
    output wpp_pkg::wpp_entry_t head,
    output logic                empty,
    output logic                full
);

    wpp_pkg::wpp_entry_t entries [wpp_pkg::QUEUE_DEPTH];
    logic [wpp_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [wpp_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == wpp_pkg::QUEUE_CNT_W'(wpp_pkg::QUEUE_DEPTH));
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + wpp_pkg::QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - wpp_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + wpp_pkg::QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + wpp_pkg::QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue pushed while full");

endmodule

### rtl/wpp_back.sv
// ----------------------------------------------------------------------------
// wpp_back
// Output stage: turns queue entries into result transfers, sample first.
// ----------------------------------------------------------------------------
module wpp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  wpp_pkg::wpp_entry_t head,
    input  logic                empty,
    output logic                pop,
    wpp_out_if.source           result_out
);

    logic        out_valid_reg, out_valid_next;
    logic        sample_done_reg, sample_done_next;
    logic        kind_reg, kind_next;
    logic [15:0] sample_reg, sample_next;
    logic        first_reg, first_next;
    logic [15:0] channels_reg, channels_next;
    logic [31:0] rate_reg, rate_next;
    logic [2:0]  status_reg, status_next;
    logic        load;

    assign load = !out_valid_reg || result_out.ready;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        sample_done_next = sample_done_reg;
        kind_next        = kind_reg;
        sample_next      = sample_reg;
        first_next       = first_reg;
        channels_next    = channels_reg;
        rate_next        = rate_reg;
        status_next      = status_reg;
        pop              = 1'b0;

        if (load)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                if (head.sample_valid && !sample_done_reg)
                begin
                    kind_next     = wpp_pkg::KIND_SAMPLE;
                    sample_next   = head.sample;
                    first_next    = head.first_of_chunk;
                    channels_next = 16'd0;
                    rate_next     = 32'd0;
                    status_next   = wpp_pkg::ST_OK;
                    // A status behind the sample keeps the entry in the queue until it is sent.
                    if (head.status_valid)
                    begin
                        sample_done_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                else
                begin
                    kind_next        = wpp_pkg::KIND_STATUS;
                    sample_next      = 16'd0;
                    first_next       = 1'b0;
                    channels_next    = head.channels;
                    rate_next        = head.sample_rate;
                    status_next      = head.status;
                    sample_done_next = 1'b0;
                    pop              = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            sample_done_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            sample_done_reg <= sample_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        sample_reg   <= sample_next;
        first_reg    <= first_next;
        channels_reg <= channels_next;
        rate_reg     <= rate_next;
        status_reg   <= status_next;
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.kind           = kind_reg;
    assign result_out.sample         = $signed(sample_reg);
    assign result_out.first_of_chunk = first_reg;
    assign result_out.channels       = channels_reg;
    assign result_out.sample_rate    = rate_reg;
    assign result_out.status         = status_reg;
    assign result_out.last           = (kind_reg == wpp_pkg::KIND_STATUS);

    // A half-delivered entry must still be at the head and carry both results.
    a_split_entry: assert property (@(posedge clk) disable iff (!rst_n)
        sample_done_reg |-> (!empty && head.sample_valid && head.status_valid))
        else $error("sample sent but its status entry is gone");

endmodule

### rtl/wav_pcm16_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// wav_pcm16_stream_parser_unit
// RIFF WAVE 16-bit PCM parser: file bytes in, samples and a final status out.
// ----------------------------------------------------------------------------
// Usage:
// The byte_in channel takes one file byte per transfer, with end_of_file set
// on the last byte of a file. The result_out channel delivers signed 16-bit
// samples (kind 0) as each little-endian pair of a data chunk completes, and
// one status transfer (kind 1, last set) for the end-of-file byte, carrying
// the channel count and sample rate when the status is 0. A sample with
// first_of_chunk set begins a new data chunk, and the consumer drops all
// earlier samples; on a nonzero status every sample of the file is dropped.
// Throughput is one byte per cycle while the queue has room. The parser
// updates its state in the same cycle as the transfer, writes the results of
// the byte into a four-entry queue, and the output register presents them
// one per cycle while the receiver is ready. The end-of-file byte can cause
// a sample and the status; the output stage then sends both from that entry.
// When the receiver stalls, the queue fills and byte_in.ready drops once it
// is full; nothing is lost. After reset, and after every end-of-file byte,
// the parser expects the RIFF header of a new file.
// ----------------------------------------------------------------------------
module wav_pcm16_stream_parser_unit (
    input  logic      clk,
    input  logic      rst_n,
    wpp_in_if.sink    byte_in,
    wpp_out_if.source result_out
);

    // Entry pushed by the parser for each byte that causes a result.
    wpp_pkg::wpp_entry_t push_entry;
    wpp_pkg::wpp_entry_t head;
    logic                push;
    logic                pop;
    logic                empty;
    logic                full;

    // Front part: classifies each byte and tracks the chunk structure.
    wpp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue decouples parsing from result delivery.
    wpp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    // Back part: serializes each entry into one or two result transfers.
    wpp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule

### dv/wav_pcm16_stream_parser_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wav_pcm16_stream_parser_unit_tb
// Self-checking bench for the WAVE parser. Whole files are built as byte
// streams, fed through the byte channel with random gaps, and every result is
// checked against a cycle-free model of the parser kept inside the bench.
// ----------------------------------------------------------------------------
module wav_pcm16_stream_parser_unit_tb;

    // One pending input transfer. drain_first holds the byte back until every
    // outstanding result has been seen, so the parser runs completely empty.
    typedef struct packed {
        logic       drain_first;
        logic       end_of_file;
        logic [7:0] data;
    } byte_item_t;

    // One result as the output channel should present it.
    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample;
        logic               first_of_chunk;
        logic [15:0]        channels;
        logic [31:0]        sample_rate;
        logic [2:0]         status;
        logic               last;
    } parse_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wpp_in_if  byte_in_if ();
    wpp_out_if result_out_if ();

    wav_pcm16_stream_parser_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in_if),
        .result_out (result_out_if)
    );

    always #5 clk = ~clk;

    // Stimulus and scoreboard storage.
    byte_item_t    pending_bytes[$];
    parse_result_t expected_results[$];
    logic [7:0]    file_bytes[$];
    int            bytes_left   = 0;
    int            error_count  = 0;

    // Handshake bookkeeping between the rising-edge monitor and the
    // falling-edge drivers.
    bit         byte_taken   = 1'b0;
    bit         result_taken = 1'b0;
    int         tx_gap       = 0;
    int         rx_stall     = 0;
    bit         tx_steady    = 1'b0;
    bit         rx_steady    = 1'b0;
    byte_item_t next_item;

    // ------------------------------------------------------------------------
    // Parser model state. It mirrors the block's registers one for one and is
    // cleared after reset and after every end-of-file byte.
    // ------------------------------------------------------------------------
    wpp_pkg::phase_t parse_phase;
    logic [3:0]      hdr_count;
    logic [31:0]     tag_acc;
    logic [31:0]     chunk_len;
    logic [31:0]     body_pos;
    logic [7:0]      held_low;
    logic [15:0]     fmt_code;
    logic [15:0]     bits_per_sample;
    logic [15:0]     chan_count;
    logic [31:0]     rate_acc;
    logic            fmt_seen;
    logic            data_seen;
    logic [2:0]      first_error;
    logic            chunk_start_pending;

    function automatic void clear_parser_state();
        parse_phase         = wpp_pkg::PH_FILE_HDR;
        hdr_count           = '0;
        tag_acc             = '0;
        chunk_len           = '0;
        body_pos            = '0;
        held_low            = '0;
        fmt_code            = '0;
        bits_per_sample     = '0;
        chan_count          = '0;
        rate_acc            = '0;
        fmt_seen            = 1'b0;
        data_seen           = 1'b0;
        first_error         = wpp_pkg::ST_OK;
        chunk_start_pending = 1'b0;
    endfunction

    // Only the first error of a file is kept; the rest of the file is skipped.
    function automatic void flag_error(input logic [2:0] code);
        if (first_error == wpp_pkg::ST_OK)
            first_error = code;
        parse_phase = wpp_pkg::PH_SKIP;
    endfunction

    // A chunk body has completed. The fmt checks are deferred to this point,
    // which is why a fmt chunk cut short by end of file reports an overrun.
    function automatic void close_chunk();
        if (tag_acc == wpp_pkg::TAG_FMT && chunk_len < wpp_pkg::FMT_MIN_LENGTH)
        begin
            flag_error(wpp_pkg::ST_FMT_SHORT);
        end
        else if (tag_acc == wpp_pkg::TAG_FMT &&
                 (fmt_code != wpp_pkg::PCM_FORMAT ||
                  bits_per_sample != wpp_pkg::PCM_BITS))
        begin
            flag_error(wpp_pkg::ST_UNSUPPORTED);
        end
        else
        begin
            if (tag_acc == wpp_pkg::TAG_FMT)
                fmt_seen = 1'b1;
            else if (tag_acc == wpp_pkg::TAG_DATA)
                data_seen = 1'b1;
            parse_phase = chunk_len[0] ? wpp_pkg::PH_PAD : wpp_pkg::PH_CHUNK_HDR;
        end
    endfunction

    // Advances the model by one accepted byte and queues what it must cause:
    // at most one sample, then the status on an end-of-file byte.
    function automatic void predict_byte(input logic [7:0] b, input logic eof);
        parse_result_t res;
        logic [2:0]    st;
        case (parse_phase)
            wpp_pkg::PH_FILE_HDR:
            begin
                tag_acc = {tag_acc[23:0], b};
                if (hdr_count == wpp_pkg::RIFF_LAST_BYTE && tag_acc != wpp_pkg::TAG_RIFF)
                begin
                    flag_error(wpp_pkg::ST_NOT_WAVE);
                end
                else if (hdr_count == wpp_pkg::FILE_HDR_LAST &&
                         tag_acc != wpp_pkg::TAG_WAVE)
                begin
                    flag_error(wpp_pkg::ST_NOT_WAVE);
                end
                else if (hdr_count == wpp_pkg::FILE_HDR_LAST)
                begin
                    hdr_count   = '0;
                    parse_phase = wpp_pkg::PH_CHUNK_HDR;
                end
                else
                begin
                    hdr_count++;
                end
            end
            wpp_pkg::PH_CHUNK_HDR:
            begin
                if (hdr_count == 4'd0)
                    chunk_len = '0;
                if (hdr_count < 4'd4)
                    tag_acc = {tag_acc[23:0], b};
                else
                    chunk_len[{hdr_count[1:0], 3'b000} +: 8] = b;
                if (hdr_count == wpp_pkg::CHUNK_HDR_LAST)
                begin
                    hdr_count           = '0;
                    body_pos            = '0;
                    held_low            = '0;
                    chunk_start_pending = (tag_acc == wpp_pkg::TAG_DATA);
                    if (chunk_len == 32'd0)
                        close_chunk();
                    else
                        parse_phase = wpp_pkg::PH_BODY;
                end
                else
                begin
                    hdr_count++;
                end
            end
            wpp_pkg::PH_BODY:
            begin
                if (tag_acc == wpp_pkg::TAG_FMT)
                begin
                    // Byte offsets of the PCM fields inside the fmt body.
                    case (body_pos)
                        32'd0:  fmt_code[7:0]         = b;
                        32'd1:  fmt_code[15:8]        = b;
                        32'd2:  chan_count[7:0]       = b;
                        32'd3:  chan_count[15:8]      = b;
                        32'd4, 32'd5, 32'd6, 32'd7:
                                rate_acc[{body_pos[1:0], 3'b000} +: 8] = b;
                        32'd14: bits_per_sample[7:0]  = b;
                        32'd15: bits_per_sample[15:8] = b;
                        default: ;
                    endcase
                end
                else if (tag_acc == wpp_pkg::TAG_DATA)
                begin
                    if (body_pos[0])
                    begin
                        res                = '0;
                        res.kind           = wpp_pkg::KIND_SAMPLE;
                        res.sample         = {b, held_low};
                        res.first_of_chunk = chunk_start_pending;
                        expected_results.push_back(res);
                        chunk_start_pending = 1'b0;
                    end
                    else
                    begin
                        held_low = b;
                    end
                end
                body_pos++;
                if (body_pos == chunk_len)
                    close_chunk();
            end
            wpp_pkg::PH_PAD: parse_phase = wpp_pkg::PH_CHUNK_HDR;
            default: ;
        endcase

        if (eof)
        begin
            st = first_error;
            if (st == wpp_pkg::ST_OK && parse_phase == wpp_pkg::PH_FILE_HDR)
                st = wpp_pkg::ST_NOT_WAVE;
            if (st == wpp_pkg::ST_OK && parse_phase == wpp_pkg::PH_BODY)
                st = wpp_pkg::ST_OVERRUN;
            if (st == wpp_pkg::ST_OK && (!fmt_seen || !data_seen ||
                                         chan_count == 16'd0 || rate_acc == 32'd0))
                st = wpp_pkg::ST_MISSING;
            res             = '0;
            res.kind        = wpp_pkg::KIND_STATUS;
            res.channels    = (st == wpp_pkg::ST_OK) ? chan_count : 16'd0;
            res.sample_rate = (st == wpp_pkg::ST_OK) ? rate_acc : 32'd0;
            res.status      = st;
            res.last        = 1'b1;
            expected_results.push_back(res);
            clear_parser_state();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Error reporting. Every mismatch prints one line and is counted.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // File builders. A file is assembled in file_bytes and then moved to the
    // pending transfers, optionally cut short, with end_of_file on its last
    // byte.
    // ------------------------------------------------------------------------
    task automatic put_tag(input logic [31:0] tag);
        file_bytes.push_back(tag[31:24]);
        file_bytes.push_back(tag[23:16]);
        file_bytes.push_back(tag[15:8]);
        file_bytes.push_back(tag[7:0]);
    endtask

    task automatic put_le32(input logic [31:0] value);
        file_bytes.push_back(value[7:0]);
        file_bytes.push_back(value[15:8]);
        file_bytes.push_back(value[23:16]);
        file_bytes.push_back(value[31:24]);
    endtask

    task automatic put_wave_header();
        put_tag(wpp_pkg::TAG_RIFF);
        put_le32($urandom);
        put_tag(wpp_pkg::TAG_WAVE);
    endtask

    task automatic put_chunk_hdr(input logic [31:0] tag, input logic [31:0] len);
        put_tag(tag);
        put_le32(len);
    endtask

    // A chunk with a random body and its pad byte when the length is odd.
    task automatic put_chunk(input logic [31:0] tag, input logic [31:0] len);
        int i;
        put_chunk_hdr(tag, len);
        for (i = 0; i < len; i++)
            file_bytes.push_back(8'($urandom_range(0, 255)));
        if (len[0])
            file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_fmt(input logic [31:0] len, input logic [15:0] code,
                           input logic [15:0] chans, input logic [31:0] rate,
                           input logic [15:0] bits_val);
        int i;
        put_chunk_hdr(wpp_pkg::TAG_FMT, len);
        for (i = 0; i < len; i++)
        begin
            case (i)
                0:          file_bytes.push_back(code[7:0]);
                1:          file_bytes.push_back(code[15:8]);
                2:          file_bytes.push_back(chans[7:0]);
                3:          file_bytes.push_back(chans[15:8]);
                4, 5, 6, 7: file_bytes.push_back(rate[8*(i-4) +: 8]);
                14:         file_bytes.push_back(bits_val[7:0]);
                15:         file_bytes.push_back(bits_val[15:8]);
                default:    file_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        if (len[0])
            file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic flush_file(input int keep, input bit drain);
        int         i;
        byte_item_t item;
        for (i = 0; i < keep; i++)
        begin
            item.drain_first = drain && (i == 0);
            item.end_of_file = (i == keep - 1);
            item.data        = file_bytes[i];
            pending_bytes.push_back(item);
        end
        bytes_left += keep;
        file_bytes.delete();
    endtask

    // ------------------------------------------------------------------------
    // Byte driver. It changes the channel only at the falling edge. A byte
    // stays on the channel until the monitor has seen its transfer, and after
    // each transfer a random gap is drawn, except during steady stretches
    // where the bytes go back to back.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && !(byte_in_if.valid && !byte_taken))
        begin
            byte_taken = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                byte_in_if.valid <= 1'b0;
            end
            else if (pending_bytes.size() == 0 ||
                     (pending_bytes[0].drain_first && expected_results.size() != 0))
            begin
                byte_in_if.valid <= 1'b0;
            end
            else
            begin
                next_item = pending_bytes.pop_front();
                byte_in_if.valid       <= 1'b1;
                byte_in_if.data_byte   <= next_item.data;
                byte_in_if.end_of_file <= next_item.end_of_file;
                if ($urandom_range(0, 63) == 0)
                    tx_steady = !tx_steady;
                tx_gap = tx_steady ? 0 : $urandom_range(0, 3);
            end
        end
    end

    // Result receiver. After each result transfer it draws a random stall,
    // again with steady stretches where ready stays high.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                if ($urandom_range(0, 63) == 0)
                    rx_steady = !rx_steady;
                rx_stall = rx_steady ? 0 : $urandom_range(0, 3);
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                result_out_if.ready <= 1'b0;
            end
            else
            begin
                result_out_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. At each rising edge an accepted byte advances the model, and an
    // accepted result is checked field by field against the oldest
    // expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n)
        begin
            if (byte_in_if.valid && byte_in_if.ready)
            begin
                predict_byte(byte_in_if.data_byte, byte_in_if.end_of_file);
                byte_taken = 1'b1;
                bytes_left--;
            end
            if (result_out_if.valid && result_out_if.ready)
            begin
                result_taken = 1'b1;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result transfer with nothing expected");
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", 32'(result_out_if.kind), 32'(want.kind));
                    check_field("sample", 32'(result_out_if.sample), 32'(want.sample));
                    check_field("first_of_chunk", 32'(result_out_if.first_of_chunk),
                                32'(want.first_of_chunk));
                    check_field("channels", 32'(result_out_if.channels),
                                32'(want.channels));
                    check_field("sample_rate", result_out_if.sample_rate,
                                want.sample_rate);
                    check_field("status", 32'(result_out_if.status), 32'(want.status));
                    check_field("last", 32'(result_out_if.last), 32'(want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------------
    initial
    begin
        int          total_items;
        int          choice;
        int          n_chunks;
        int          c;
        int          k;
        int          pick;
        int          keep;
        int          flip_pos;
        bit          drain;
        bit          first_random;
        logic [31:0] fmt_len;
        logic [31:0] rate;
        logic [15:0] code;
        logic [15:0] chans;
        logic [15:0] bits_val;

        byte_in_if.valid       = 1'b0;
        byte_in_if.data_byte   = 8'h00;
        byte_in_if.end_of_file = 1'b0;
        result_out_if.ready    = 1'b0;
        clear_parser_state();

        // Directed files. A one-byte file ends inside the file header.
        file_bytes.push_back(8'h52);
        flush_file(1, 1'b0);

        // A bad RIFF tag; the well-formed rest is ignored, the first error wins.
        put_tag(32'h5249_4658);
        put_le32(32'd0);
        put_tag(wpp_pkg::TAG_WAVE);
        put_fmt(32'd16, wpp_pkg::PCM_FORMAT, 16'd1, 32'd8000, wpp_pkg::PCM_BITS);
        flush_file(file_bytes.size(), 1'b0);

        // A clean file with the sample extremes and the largest rate.
        put_wave_header();
        put_fmt(32'd16, wpp_pkg::PCM_FORMAT, 16'd2, 32'hFFFF_FFFF, wpp_pkg::PCM_BITS);
        put_chunk_hdr(wpp_pkg::TAG_DATA, 32'd8);
        file_bytes.push_back(8'h00); file_bytes.push_back(8'h80);
        file_bytes.push_back(8'hFF); file_bytes.push_back(8'h7F);
        file_bytes.push_back(8'h00); file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF); file_bytes.push_back(8'hFF);
        flush_file(file_bytes.size(), 1'b1);

        // Odd-sized chunks with pad bytes, a skipped chunk, the largest channel
        // count, several data chunks, an empty one among them, and a final odd
        // data chunk whose pad byte never comes.
        put_wave_header();
        put_chunk(32'h4C49_5354, 32'd3);
        put_fmt(32'd17, wpp_pkg::PCM_FORMAT, 16'hFFFF, 32'd1, wpp_pkg::PCM_BITS);
        put_chunk(wpp_pkg::TAG_DATA, 32'd5);
        put_chunk(wpp_pkg::TAG_DATA, 32'd2);
        put_chunk(wpp_pkg::TAG_DATA, 32'd1);
        put_chunk(wpp_pkg::TAG_DATA, 32'd0);
        put_chunk(wpp_pkg::TAG_DATA, 32'd3);
        flush_file(file_bytes.size() - 1, 1'b0);

        // Short fmt chunk, then unsupported format code and bit depth.
        put_wave_header();
        put_fmt(32'd14, wpp_pkg::PCM_FORMAT, 16'd1, 32'd44100, wpp_pkg::PCM_BITS);
        put_chunk(wpp_pkg::TAG_DATA, 32'd4);
        flush_file(file_bytes.size(), 1'b0);
        put_wave_header();
        put_fmt(32'd16, 16'd3, 16'd1, 32'd44100, wpp_pkg::PCM_BITS);
        put_chunk(wpp_pkg::TAG_DATA, 32'd2);
        flush_file(file_bytes.size(), 1'b0);
        put_wave_header();
        put_fmt(32'd16, wpp_pkg::PCM_FORMAT, 16'd1, 32'd44100, 16'd8);
        flush_file(file_bytes.size(), 1'b0);

        // Missing pieces: zero channels, zero rate, no data, no fmt.
        put_wave_header();
        put_fmt(32'd16, wpp_pkg::PCM_FORMAT, 16'd0, 32'd44100, wpp_pkg::PCM_BITS);
        put_chunk(wpp_pkg::TAG_DATA, 32'd2);
        flush_file(file_bytes.size(), 1'b0);
        put_wave_header();
        put_fmt(32'd16, wpp_pkg::PCM_FORMAT, 16'd1, 32'd0, wpp_pkg::PCM_BITS);
        put_chunk(wpp_pkg::TAG_DATA, 32'd2);
        flush_file(file_bytes.size(), 1'b0);
        put_wave_header();
        put_fmt(32'd16, wpp_pkg::PCM_FORMAT, 16'd1, 32'd22050, wpp_pkg::PCM_BITS);
        flush_file(file_bytes.size(), 1'b0);
        put_wave_header();
        put_chunk(wpp_pkg::TAG_DATA, 32'd2);
        flush_file(file_bytes.size(), 1'b0);

        // A fmt chunk cut off by end of file reports an overrun, not a fmt error.
        put_wave_header();
        put_fmt(32'd16, 16'd3, 16'd1, 32'd44100, wpp_pkg::PCM_BITS);
        flush_file(file_bytes.size() - 6, 1'b0);

        // End of file on the last header byte of a chunk with the largest length.
        put_wave_header();
        put_fmt(32'd16, wpp_pkg::PCM_FORMAT, 16'd1, 32'd48000, wpp_pkg::PCM_BITS);
        put_chunk_hdr(wpp_pkg::TAG_DATA, 32'hFFFF_FFFF);
        flush_file(file_bytes.size(), 1'b0);

        // A partial chunk header at end of file is simply dropped.
        put_wave_header();
        put_fmt(32'd16, wpp_pkg::PCM_FORMAT, 16'd1, 32'd48000, wpp_pkg::PCM_BITS);
        put_chunk(wpp_pkg::TAG_DATA, 32'd2);
        put_tag(wpp_pkg::TAG_DATA);
        flush_file(file_bytes.size() - 1, 1'b0);

        // A data chunk cut off in its body.
        put_wave_header();
        put_fmt(32'd16, wpp_pkg::PCM_FORMAT, 16'd1, 32'd48000, wpp_pkg::PCM_BITS);
        put_chunk(wpp_pkg::TAG_DATA, 32'd6);
        flush_file(file_bytes.size() - 3, 1'b0);

        // A bad WAVE tag, a bare file header, and a file ending inside the length after RIFF.
        put_tag(wpp_pkg::TAG_RIFF);
        put_le32(32'd0);
        put_tag(32'h5741_5646);
        flush_file(file_bytes.size(), 1'b0);
        put_wave_header();
        flush_file(file_bytes.size(), 1'b0);
        put_tag(wpp_pkg::TAG_RIFF);
        file_bytes.push_back(8'h24);
        file_bytes.push_back(8'h00);
        flush_file(file_bytes.size(), 1'b0);

        // Zero-length fmt and data chunks, ending on their last header byte.
        put_wave_header();
        put_chunk_hdr(wpp_pkg::TAG_FMT, 32'd0);
        flush_file(file_bytes.size(), 1'b0);
        put_wave_header();
        put_fmt(32'd16, wpp_pkg::PCM_FORMAT, 16'd1, 32'd8000, wpp_pkg::PCM_BITS);
        put_chunk_hdr(wpp_pkg::TAG_DATA, 32'd0);
        flush_file(file_bytes.size(), 1'b0);

        // Random files fill the run up to about 1450 bytes in total. Most are
        // well formed with random content so that the chunk walk and the
        // sample path are exercised deeply; some are cut short or damaged,
        // and the rest are noise or oversized chunks.
        total_items  = pending_bytes.size();
        first_random = 1'b1;
        while (total_items < 1450)
        begin
            choice = $urandom_range(0, 99);
            drain  = first_random || ($urandom_range(0, 19) == 0);
            if (choice < 75)
            begin
                put_wave_header();
                n_chunks = $urandom_range(1, 5);
                for (c = 0; c < n_chunks; c++)
                begin
                    pick = $urandom_range(0, 9);
                    if ((c == 0) ? (pick < 8) : (pick == 0))
                    begin
                        fmt_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) :
                                   ($urandom_range(0, 3) == 0) ? $urandom_range(17, 24) : 16;
                        code     = ($urandom_range(0, 14) == 0) ? 16'($urandom)
                                                                : wpp_pkg::PCM_FORMAT;
                        chans    = ($urandom_range(0, 9) == 0) ? 16'd0 :
                                   ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(1, 2));
                        rate     = ($urandom_range(0, 9) == 0) ? 32'd0 :
                                   ($urandom_range(0, 1) == 0) ? $urandom : 32'd44100;
                        bits_val = ($urandom_range(0, 14) == 0) ? 16'($urandom)
                                                                : wpp_pkg::PCM_BITS;
                        put_fmt(fmt_len, code, chans, rate, bits_val);
                    end
                    else if (pick < 7)
                    begin
                        put_chunk(wpp_pkg::TAG_DATA, ($urandom_range(0, 9) == 0) ?
                                  $urandom_range(0, 1) : $urandom_range(2, 16));
                    end
                    else
                    begin
                        put_chunk(($urandom_range(0, 1) == 0) ? 32'h4C49_5354 : $urandom,
                                  $urandom_range(0, 7));
                    end
                end
                keep = ($urandom_range(0, 9) < 2) ? $urandom_range(1, file_bytes.size())
                                                 : file_bytes.size();
                if ($urandom_range(0, 9) == 0)
                begin
                    flip_pos = $urandom_range(0, file_bytes.size() - 1);
                    file_bytes[flip_pos] = file_bytes[flip_pos] ^ (8'h01 << $urandom_range(0, 7));
                end
            end
            else if (choice < 90)
            begin
                if ($urandom_range(0, 1) == 0)
                    put_tag(wpp_pkg::TAG_RIFF);
                for (k = $urandom_range(1, 24); k > 0; k--)
                    file_bytes.push_back(8'($urandom_range(0, 255)));
                keep = file_bytes.size();
            end
            else
            begin
                put_wave_header();
                put_chunk_hdr(($urandom_range(0, 1) == 0) ? wpp_pkg::TAG_DATA : $urandom,
                              $urandom);
                for (k = $urandom_range(0, 10); k > 0; k--)
                    file_bytes.push_back(8'($urandom_range(0, 255)));
                keep = $urandom_range(1, file_bytes.size());
            end
            total_items += keep;
            flush_file(keep, drain);
            first_random = 1'b0;
        end

        // Reset is held low, then released at a falling edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the last byte transfer and the last expected result, then
        // keep running so that anything stray can still show up.
        while (bytes_left != 0 || expected_results.size() != 0)
            @(negedge clk);
        repeat (16) @(posedge clk);

        if (error_count == 0)
            $display("wav_pcm16_stream_parser_unit_tb: done, clean");
        else
            $display("wav_pcm16_stream_parser_unit_tb: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #2_000_000;
        $display("wav_pcm16_stream_parser_unit_tb: done, errors");
        $finish;
    end

endmodule

### files.f
rtl/wpp_pkg.sv
rtl/wpp_if.sv
rtl/wpp_front.sv
rtl/wpp_queue.sv
rtl/wpp_back.sv
rtl/wav_pcm16_stream_parser_unit.sv
dv/wav_pcm16_stream_parser_unit_tb.sv
